### hdl/lsfs_pkg.sv
// Package for the serial LCD frame sender: payload structs, engine phases,
// frame and boot-sequence constants and small table functions.
// No dependencies.
package lsfs_pkg;

   localparam int WAIT_COUNTER_BITS = 16;
   localparam int FRAME_BITS        = 24;
   localparam int BIT_INDEX_BITS    = 5;
   localparam int INIT_STEP_BITS    = 4;
   localparam int PHASE_TICK_BITS   = 8;
   localparam int FRAME_GAP_BITS    = 10;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;

   localparam logic [7:0] SYNC_DATA = 8'hFA;
   localparam logic [7:0] SYNC_CMD  = 8'hF8;

   localparam logic [WAIT_COUNTER_BITS-1:0] RST_LOW_TICKS  = WAIT_COUNTER_BITS'(10000);
   localparam logic [WAIT_COUNTER_BITS-1:0] RST_HOLD_TICKS = WAIT_COUNTER_BITS'(50000);

   localparam logic [PHASE_TICK_BITS-1:0] PHASE_TICKS_RESET = 8'd1;
   localparam logic [FRAME_GAP_BITS-1:0]  FRAME_GAP_RESET   = 10'd72;

   localparam logic CSR_PHASE_TICKS = 1'b0;
   localparam logic CSR_FRAME_GAP   = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_CURSOR = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_FRAME,
      CMD_INIT
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CS_SETUP,
      PH_DATA,
      PH_CLK_HIGH,
      PH_CLK_LOW,
      PH_GAP,
      PH_RST_LOW,
      PH_HOLD
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       is_data;
      logic [1:0] row;
      logic [3:0] col;
   } req_type;

   typedef struct packed {
      logic sclk;
      logic sid;
      logic cs;
      logic rst_res;
      logic busy_res;
      logic accepted;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [FRAME_BITS-1:0] frame;
   } cmd_type;

   typedef struct packed {
      logic rst;
      logic cs;
      logic sid;
      logic sclk;
   } pins_type;

   typedef struct packed {
      logic [PHASE_TICK_BITS-1:0] phase_ticks;
      logic [FRAME_GAP_BITS-1:0]  frame_gap_ticks;
   } cfg_type;

   function automatic logic [FRAME_BITS-1:0] frame_word(input logic [7:0] value,
                                                        input logic       is_data);
      logic [7:0] sync;
      sync = is_data ? SYNC_DATA : SYNC_CMD;
      return {sync, value[7:4], 4'b0000, value[3:0], 4'b0000};
   endfunction

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'h90;
         2'd2:    base = 8'h88;
         default: base = 8'h98;
      endcase
      return base;
   endfunction

   function automatic logic [7:0] boot_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      case (idx)
         3'd0:    cmd = 8'h30;
         3'd1:    cmd = 8'h30;
         3'd2:    cmd = 8'h0C;
         3'd3:    cmd = 8'h01;
         default: cmd = 8'h06;
      endcase
      return cmd;
   endfunction

   function automatic logic [WAIT_COUNTER_BITS-1:0] boot_wait(input logic [2:0] idx);
      logic [WAIT_COUNTER_BITS-1:0] w;
      case (idx)
         3'd0:    w = WAIT_COUNTER_BITS'(100);
         3'd1:    w = WAIT_COUNTER_BITS'(37);
         3'd2:    w = WAIT_COUNTER_BITS'(100);
         3'd3:    w = WAIT_COUNTER_BITS'(10000);
         default: w = WAIT_COUNTER_BITS'(100);
      endcase
      return w;
   endfunction

endpackage

### hdl/lcd_serial_frame_sender_top.sv
// Top level of the serial LCD frame sender: configuration registers and the
// front/back split. Depends on lsfs_pkg, lsfs_front and lsfs_back.
//
// Usage: request beats enter through push/full on req_data; each is a tick
// (one microsecond of time), a byte write, a cursor move or an init run.
// Every request beat yields exactly one result beat on rsp_data, read
// through empty/pop: the pin levels after the beat, busy_res, and accepted
// (high only for a write, cursor or init request taken while idle).
// A result beat is registered into the result buffer when the sequencer
// applies its command; one beat per cycle is sustained while the result
// buffer has room. Two-entry queues on each side let the input keep
// flowing while a result waits; a stalled receiver fills the result buffer,
// then the command queue, and then full rises. phase_ticks (address 0) and
// frame_gap_ticks (address 4) are written through the APB port; the user
// must write them only while no beat is in flight, and the block does not
// enforce this. Reset clears both queues, puts the sequencer idle with all
// pins low and loads phase_ticks 1 and frame_gap_ticks 72.
module lcd_serial_frame_sender_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  lsfs_pkg::req_type                      req_data,
   output logic                                   empty,
   input  logic                                   pop,
   output lsfs_pkg::rsp_type                      rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [lsfs_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [lsfs_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [lsfs_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                   pready
);
   import lsfs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_PHASE_TICKS: cfg_in.phase_ticks     = pwdata[PHASE_TICK_BITS-1:0];
            CSR_FRAME_GAP:   cfg_in.frame_gap_ticks = pwdata[FRAME_GAP_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_PHASE_TICKS: prdata = CSR_DATA_BITS'(cfg_ff.phase_ticks);
         default:         prdata = CSR_DATA_BITS'(cfg_ff.frame_gap_ticks);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks     <= PHASE_TICKS_RESET;
         cfg_ff.frame_gap_ticks <= FRAME_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   lsfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/lsfs_front.sv
// Front end: classifies request beats into commands and holds them in a
// two-entry command queue for the engine. Depends on lsfs_pkg.
module lsfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lsfs_pkg::req_type req_data,
   output logic              cmd_valid,
   output lsfs_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);
   import lsfs_pkg::*;

   cmd_type    q_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic [7:0] cursor_byte;

   always_comb begin
      cursor_byte = row_base(req_data.row) + {4'b0000, req_data.col};
      cmd_in.frame = frame_word(req_data.data_byte, req_data.is_data);
      case (op_type'(req_data.op))
         OP_TICK: begin
            cmd_in.kind = CMD_TICK;
         end
         OP_WRITE: begin
            cmd_in.kind = CMD_FRAME;
         end
         OP_CURSOR: begin
            cmd_in.kind  = CMD_FRAME;
            cmd_in.frame = frame_word(cursor_byte, 1'b0);
         end
         default: begin
            cmd_in.kind = CMD_INIT;
         end
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign push_ok   = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != 2'd0)
      else $error("command queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !cmd_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("command queue lost a beat");

endmodule

### hdl/lsfs_back.sv
// Back end: the pin sequencer (one command per cycle while the result buffer
// has room) and a two-entry result buffer toward responses. Depends on lsfs_pkg.
module lsfs_back (
   input  logic              clock,
   input  logic              reset,
   input  lsfs_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  lsfs_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output lsfs_pkg::rsp_type rsp_data
);
   import lsfs_pkg::*;

   phase_type                    phase_ff, phase_in;
   logic [WAIT_COUNTER_BITS-1:0] wait_ff, wait_in;
   logic [FRAME_BITS-1:0]        shift_ff, shift_in;
   logic [BIT_INDEX_BITS-1:0]    bit_index_ff, bit_index_in;
   logic [INIT_STEP_BITS-1:0]    init_step_ff, init_step_in;
   pins_type                     pins_ff, pins_in;

   logic                         busy;
   logic                         taken;
   logic [WAIT_COUNTER_BITS-1:0] plen;
   logic [BIT_INDEX_BITS-1:0]    next_index;
   logic [BIT_INDEX_BITS-1:0]    sel_index;
   phase_type                    done_phase;
   logic [WAIT_COUNTER_BITS-1:0] done_wait;
   logic [INIT_STEP_BITS-1:0]    done_step;
   logic [INIT_STEP_BITS-1:0]    step_m1;
   logic [INIT_STEP_BITS-1:0]    step_m2;
   rsp_type                      rsp_in;

   rsp_type    buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       rsp_pop;

   assign busy    = (phase_ff != PH_IDLE);
   assign cmd_pop = cmd_valid && (count_ff != 2'd2);
   assign plen    = (cfg.phase_ticks == '0) ? WAIT_COUNTER_BITS'(1)
                                            : WAIT_COUNTER_BITS'(cfg.phase_ticks);
   assign next_index = bit_index_ff + BIT_INDEX_BITS'(1);
   assign sel_index  = BIT_INDEX_BITS'(FRAME_BITS - 1) - next_index;
   assign step_m1    = init_step_ff - INIT_STEP_BITS'(1);
   assign step_m2    = init_step_ff - INIT_STEP_BITS'(2);

   always_comb begin
      if (init_step_ff >= INIT_STEP_BITS'(2) && init_step_ff <= INIT_STEP_BITS'(6)) begin
         done_phase = PH_HOLD;
         done_wait  = boot_wait(step_m2[2:0]);
         done_step  = init_step_ff;
      end else begin
         done_phase = PH_IDLE;
         done_wait  = '0;
         done_step  = '0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      bit_index_in = bit_index_ff;
      init_step_in = init_step_ff;
      pins_in      = pins_ff;
      taken        = 1'b0;
      case (cmd_data.kind)
         CMD_TICK: begin
            if (busy) begin
               if (wait_ff > WAIT_COUNTER_BITS'(1)) begin
                  wait_in = wait_ff - WAIT_COUNTER_BITS'(1);
               end else begin
                  case (phase_ff)
                     PH_CS_SETUP: begin
                        bit_index_in = '0;
                        pins_in.sid  = shift_ff[FRAME_BITS-1];
                        phase_in     = PH_DATA;
                        wait_in      = plen;
                     end
                     PH_DATA: begin
                        pins_in.sclk = 1'b1;
                        phase_in     = PH_CLK_HIGH;
                        wait_in      = plen;
                     end
                     PH_CLK_HIGH: begin
                        pins_in.sclk = 1'b0;
                        phase_in     = PH_CLK_LOW;
                        wait_in      = plen;
                     end
                     PH_CLK_LOW: begin
                        bit_index_in = next_index;
                        if (next_index < BIT_INDEX_BITS'(FRAME_BITS)) begin
                           pins_in.sid = shift_ff[sel_index];
                           phase_in    = PH_DATA;
                           wait_in     = plen;
                        end else begin
                           pins_in.cs = 1'b0;
                           if (cfg.frame_gap_ticks == '0) begin
                              phase_in     = done_phase;
                              wait_in      = done_wait;
                              init_step_in = done_step;
                           end else begin
                              phase_in = PH_GAP;
                              wait_in  = WAIT_COUNTER_BITS'(cfg.frame_gap_ticks);
                           end
                        end
                     end
                     PH_GAP: begin
                        phase_in     = done_phase;
                        wait_in      = done_wait;
                        init_step_in = done_step;
                     end
                     PH_RST_LOW: begin
                        pins_in.rst  = 1'b1;
                        init_step_in = INIT_STEP_BITS'(1);
                        phase_in     = PH_HOLD;
                        wait_in      = RST_HOLD_TICKS;
                     end
                     PH_HOLD: begin
                        if (init_step_ff >= INIT_STEP_BITS'(1) &&
                            init_step_ff <= INIT_STEP_BITS'(5)) begin
                           shift_in     = frame_word(boot_cmd(step_m1[2:0]), 1'b0);
                           bit_index_in = '0;
                           pins_in.cs   = 1'b1;
                           phase_in     = PH_CS_SETUP;
                           wait_in      = plen;
                           init_step_in = init_step_ff + INIT_STEP_BITS'(1);
                        end else begin
                           init_step_in = '0;
                           phase_in     = PH_IDLE;
                           wait_in      = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        wait_in  = '0;
                     end
                  endcase
               end
            end
         end
         CMD_FRAME: begin
            if (!busy) begin
               taken        = 1'b1;
               shift_in     = cmd_data.frame;
               bit_index_in = '0;
               pins_in.cs   = 1'b1;
               phase_in     = PH_CS_SETUP;
               wait_in      = plen;
            end
         end
         default: begin
            if (!busy) begin
               taken        = 1'b1;
               pins_in      = '0;
               init_step_in = INIT_STEP_BITS'(1);
               phase_in     = PH_RST_LOW;
               wait_in      = RST_LOW_TICKS;
            end
         end
      endcase
   end

   always_comb begin
      rsp_in.sclk     = pins_in.sclk;
      rsp_in.sid      = pins_in.sid;
      rsp_in.cs       = pins_in.cs;
      rsp_in.rst_res  = pins_in.rst;
      rsp_in.busy_res = (phase_in != PH_IDLE);
      rsp_in.accepted = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         shift_ff     <= '0;
         bit_index_ff <= '0;
         init_step_ff <= '0;
         pins_ff      <= '0;
      end else if (cmd_pop) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         shift_ff     <= shift_in;
         bit_index_ff <= bit_index_in;
         init_step_ff <= init_step_in;
         pins_ff      <= pins_in;
      end
   end

   assign empty    = (count_ff == 2'd0);
   assign rsp_pop  = pop && !empty;
   assign rsp_data = buf_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, cmd_pop} - {1'b0, rsp_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= cmd_pop ? !wr_ptr_ff : wr_ptr_ff;
         rd_ptr_ff <= rsp_pop ? !rd_ptr_ff : rd_ptr_ff;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         buf_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   a_taken_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && taken) |-> rsp_in.busy_res)
      else $error("accepted request left the sequencer idle");

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> wait_ff == '0)
      else $error("idle sequencer holds a pending wait");

   a_cs_in_frame: assert property (@(posedge clock) disable iff (reset)
      pins_ff.cs |-> (phase_ff == PH_CS_SETUP || phase_ff == PH_DATA ||
                      phase_ff == PH_CLK_HIGH || phase_ff == PH_CLK_LOW))
      else $error("chip select high outside a frame");

   a_bit_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA || phase_ff == PH_CLK_HIGH || phase_ff == PH_CLK_LOW)
      |-> bit_index_ff < BIT_INDEX_BITS'(FRAME_BITS))
      else $error("bit index past end of frame");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer overflow");

endmodule
